// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

   // Which diagonal term carries the square root for one matrix.
   typedef enum logic [1:0] {
      BR_TRACE,
      BR_X,
      BR_Y,
      BR_Z
   } branch_type;

   // Magnitudes are brought below 2^NORM_BITS before they are squared.
   localparam int NORM_BITS = 30;

endpackage

// ===== rtl/rmq_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// Pipelined integer square root, one root bit per register stage, with a
// sideband tag that travels alongside each request.
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe #(
   parameter int IN_W  = 4,
   parameter int TAG_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [IN_W-1:0]    in_rad,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [IN_W/2-1:0]  out_root,
   output logic [TAG_W-1:0]   out_tag
);

   localparam int RW    = IN_W / 2;
   localparam int REM_W = RW + 3;

   logic              valid_ff [RW];
   logic [IN_W-1:0]   rad_ff   [RW];
   logic [REM_W-1:0]  rem_ff   [RW];
   logic [RW-1:0]     root_ff  [RW];
   logic [TAG_W-1:0]  tag_ff   [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic              p_valid;
      logic [IN_W-1:0]   p_rad;
      logic [REM_W-1:0]  p_rem;
      logic [RW-1:0]     p_root;
      logic [TAG_W-1:0]  p_tag;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [RW-1:0]     root_in;

      if (i == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rad   = in_rad;
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_tag   = in_tag;
      end else begin : g_next
         assign p_valid = valid_ff[i-1];
         assign p_rad   = rad_ff[i-1];
         assign p_rem   = rem_ff[i-1];
         assign p_root  = root_ff[i-1];
         assign p_tag   = tag_ff[i-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      always_comb begin
         cur   = {p_rem[REM_W-3:0], p_rad[IN_W-1 -: 2]};
         trial = {1'b0, p_root, 2'b01};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {p_root[RW-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {p_root[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= p_valid;
         end
         rad_ff[i]  <= p_rad << 2;
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         tag_ff[i]  <= p_tag;
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

// ===== rtl/rmq_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. Several
// dividends share one divisor; a sideband tag travels with each request.
// ----------------------------------------------------------------------------
module rmq_div_pipe #(
   parameter int NUM_W = 4,
   parameter int DEN_W = 2,
   parameter int LANES = 1,
   parameter int TAG_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]   in_num,
   input  logic [DEN_W-1:0]              in_den,
   input  logic [TAG_W-1:0]              in_tag,
   output logic                          out_valid,
   output logic [LANES-1:0][NUM_W-1:0]   out_quo,
   output logic [TAG_W-1:0]              out_tag
);

   logic                          valid_ff [NUM_W];
   logic [LANES-1:0][NUM_W-1:0]   q_ff     [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]   rem_ff   [NUM_W];
   logic [DEN_W-1:0]              den_ff   [NUM_W];
   logic [TAG_W-1:0]              tag_ff   [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic                          p_valid;
      logic [LANES-1:0][NUM_W-1:0]   p_q;
      logic [LANES-1:0][DEN_W-1:0]   p_rem;
      logic [DEN_W-1:0]              p_den;
      logic [TAG_W-1:0]              p_tag;
      logic [LANES-1:0][DEN_W:0]     cur;
      logic [LANES-1:0][NUM_W-1:0]   q_in;
      logic [LANES-1:0][DEN_W-1:0]   rem_in;

      if (i == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_q     = in_num;
         assign p_rem   = '0;
         assign p_den   = in_den;
         assign p_tag   = in_tag;
      end else begin : g_next
         assign p_valid = valid_ff[i-1];
         assign p_q     = q_ff[i-1];
         assign p_rem   = rem_ff[i-1];
         assign p_den   = den_ff[i-1];
         assign p_tag   = tag_ff[i-1];
      end

      // The dividend shifts out at the top while quotient bits shift in below.
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            cur[l] = {p_rem[l], p_q[l][NUM_W-1]};
            if (cur[l] >= {1'b0, p_den}) begin
               rem_in[l] = DEN_W'(cur[l] - {1'b0, p_den});
               q_in[l]   = {p_q[l][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = cur[l][DEN_W-1:0];
               q_in[l]   = {p_q[l][NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= p_valid;
         end
         q_ff[i]   <= q_in;
         rem_ff[i] <= rem_in;
         den_ff[i] <= p_den;
         tag_ff[i] <= p_tag;
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = q_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts one 3x3 rotation matrix per request into a unit quaternion by
// Shepperd's method, then renormalizes it to unit length.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Handshake
//  request   req_r00 .. req_r22            start high, busy low at the edge
//  result    rsp_quat_w/x/y/z, rsp_degenerate  rsp_valid strobe, one cycle
//
// A new request is taken every cycle; busy is always low. A request passes
// through the input register, the scale square-root pipeline, the three-lane
// divider pipeline, the renormalization registers, the norm square-root
// pipeline, the four-lane divider pipeline and the output register.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
   parameter int DATA_WIDTH = 18,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [DATA_WIDTH-1:0]  req_r00,
   input  logic signed [DATA_WIDTH-1:0]  req_r01,
   input  logic signed [DATA_WIDTH-1:0]  req_r02,
   input  logic signed [DATA_WIDTH-1:0]  req_r10,
   input  logic signed [DATA_WIDTH-1:0]  req_r11,
   input  logic signed [DATA_WIDTH-1:0]  req_r12,
   input  logic signed [DATA_WIDTH-1:0]  req_r20,
   input  logic signed [DATA_WIDTH-1:0]  req_r21,
   input  logic signed [DATA_WIDTH-1:0]  req_r22,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_w,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0]  rsp_quat_z,
   output logic                          rsp_degenerate
);

   localparam int NB    = rmq_pkg::NORM_BITS;
   localparam int AW    = ((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
   localparam int NMW   = DATA_WIDTH + 1;
   localparam int SQ1_W = (AW - 1 + FRAC_BITS) + ((AW - 1 + FRAC_BITS) % 2);
   localparam int R1    = SQ1_W / 2;
   localparam int NW1   = NMW + FRAC_BITS;
   localparam int MW    = NW1;
   localparam int K_W   = $clog2(MW + 1);
   localparam int SH_W  = (MW > NB) ? MW : NB;
   localparam int SQ2_W = 2 * NB + 2;
   localparam int R2    = SQ2_W / 2;
   localparam int QW    = NB + FRAC_BITS;

   localparam logic signed [AW-1:0] ONE_A = AW'(64'd1 << FRAC_BITS);
   localparam logic [DATA_WIDTH-1:0] W_ONE = (FRAC_BITS < DATA_WIDTH - 1)
      ? DATA_WIDTH'(64'd1 << FRAC_BITS)
      : DATA_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic [QW-1:0] NEG_MAX = QW'(64'd1 << (DATA_WIDTH - 1));

   typedef struct packed {
      logic                      degen;
      rmq_pkg::branch_type       br;
      logic [2:0]                neg;
      logic [2:0][NMW-1:0]       mag;
   } tag1_type;

   typedef struct packed {
      logic                      degen;
      rmq_pkg::branch_type       br;
      logic [2:0]                neg;
      logic [R1-2:0]             own;
   } tag2_type;

   typedef struct packed {
      logic                      degen;
      logic [3:0]                neg;
      logic [3:0][NB-1:0]        m;
   } tag3_type;

   typedef struct packed {
      logic                      degen;
      logic [3:0]                neg;
   } tag4_type;

   assign busy = 1'b0;

   // ---------------------------------------------------------------- front
   logic signed [AW-1:0]   e00, e11, e22, tr, arg_in;
   logic signed [NMW-1:0]  d_zy, d_xz, d_yx, s_xy, s_xz, s_yz;
   logic signed [NMW-1:0]  num_in [3];
   rmq_pkg::branch_type    br_in;

   always_comb begin
      e00  = AW'(req_r00);
      e11  = AW'(req_r11);
      e22  = AW'(req_r22);
      tr   = e00 + e11 + e22;
      d_zy = NMW'(req_r21) - NMW'(req_r12);
      d_xz = NMW'(req_r02) - NMW'(req_r20);
      d_yx = NMW'(req_r10) - NMW'(req_r01);
      s_xy = NMW'(req_r01) + NMW'(req_r10);
      s_xz = NMW'(req_r02) + NMW'(req_r20);
      s_yz = NMW'(req_r12) + NMW'(req_r21);
      if (tr > 0) begin
         br_in  = rmq_pkg::BR_TRACE;
         arg_in = tr + ONE_A;
      end else if (e00 > e11 && e00 > e22) begin
         br_in  = rmq_pkg::BR_X;
         arg_in = ONE_A + e00 - e11 - e22;
      end else if (e11 > e22) begin
         br_in  = rmq_pkg::BR_Y;
         arg_in = ONE_A + e11 - e00 - e22;
      end else begin
         br_in  = rmq_pkg::BR_Z;
         arg_in = ONE_A + e22 - e00 - e11;
      end
      // Lanes hold the three components other than the branch's own, in order.
      unique case (br_in)
         rmq_pkg::BR_TRACE: begin
            num_in[0] = d_zy; num_in[1] = d_xz; num_in[2] = d_yx;
         end
         rmq_pkg::BR_X: begin
            num_in[0] = d_zy; num_in[1] = s_xy; num_in[2] = s_xz;
         end
         rmq_pkg::BR_Y: begin
            num_in[0] = d_xz; num_in[1] = s_xy; num_in[2] = s_yz;
         end
         default: begin
            num_in[0] = d_yx; num_in[1] = s_xz; num_in[2] = s_yz;
         end
      endcase
   end

   logic                    s1_vld_ff;
   logic signed [AW-1:0]    s1_arg_ff;
   rmq_pkg::branch_type     s1_br_ff;
   logic signed [NMW-1:0]   s1_num_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
      end
      s1_arg_ff <= arg_in;
      s1_br_ff  <= br_in;
      s1_num_ff <= num_in;
   end

   // ---------------------------------------------------------- scale root
   logic              arg_pos;
   logic [SQ1_W-1:0]  rad1;
   tag1_type          t1_in, t1_out;
   logic              sq1_vld;
   logic [R1-1:0]     root1;

   always_comb begin
      arg_pos = (s1_arg_ff > 0);
      rad1    = arg_pos ? SQ1_W'({s1_arg_ff[AW-2:0], {FRAC_BITS{1'b0}}}) : '0;
      t1_in.degen = !arg_pos;
      t1_in.br    = s1_br_ff;
      for (int l = 0; l < 3; l++) begin
         t1_in.neg[l] = s1_num_ff[l][NMW-1];
         t1_in.mag[l] = s1_num_ff[l][NMW-1] ? NMW'(-s1_num_ff[l]) : NMW'(s1_num_ff[l]);
      end
   end

   rmq_sqrt_pipe #(
      .IN_W  (SQ1_W),
      .TAG_W ($bits(tag1_type))
   ) u_sqrt_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_rad    (rad1),
      .in_tag    (t1_in),
      .out_valid (sq1_vld),
      .out_root  (root1),
      .out_tag   (t1_out)
   );

   // ------------------------------------------------ off-diagonal divides
   logic [2:0][NW1-1:0]  div1_num;
   logic [R1:0]          div1_den;
   tag2_type             t2_in, t2_out;
   logic                 dv1_vld;
   logic [2:0][NW1-1:0]  quo1;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         div1_num[l] = {t1_out.mag[l], {FRAC_BITS{1'b0}}};
      end
      div1_den    = {root1, 1'b0};
      t2_in.degen = t1_out.degen || (root1 == '0);
      t2_in.br    = t1_out.br;
      t2_in.neg   = t1_out.neg;
      t2_in.own   = root1[R1-1:1];
   end

   rmq_div_pipe #(
      .NUM_W (NW1),
      .DEN_W (R1 + 1),
      .LANES (3),
      .TAG_W ($bits(tag2_type))
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq1_vld),
      .in_num    (div1_num),
      .in_den    (div1_den),
      .in_tag    (t2_in),
      .out_valid (dv1_vld),
      .out_quo   (quo1),
      .out_tag   (t2_out)
   );

   // ------------------------------------------------------ renormalization
   logic [MW-1:0]  asm_mag [4];
   logic [3:0]     asm_neg;
   logic [MW-1:0]  own_ext;

   always_comb begin
      own_ext = MW'(t2_out.own);
      unique case (t2_out.br)
         rmq_pkg::BR_TRACE: begin
            asm_mag[0] = own_ext; asm_mag[1] = quo1[0];
            asm_mag[2] = quo1[1]; asm_mag[3] = quo1[2];
            asm_neg    = {t2_out.neg[2], t2_out.neg[1], t2_out.neg[0], 1'b0};
         end
         rmq_pkg::BR_X: begin
            asm_mag[0] = quo1[0]; asm_mag[1] = own_ext;
            asm_mag[2] = quo1[1]; asm_mag[3] = quo1[2];
            asm_neg    = {t2_out.neg[2], t2_out.neg[1], 1'b0, t2_out.neg[0]};
         end
         rmq_pkg::BR_Y: begin
            asm_mag[0] = quo1[0]; asm_mag[1] = quo1[1];
            asm_mag[2] = own_ext; asm_mag[3] = quo1[2];
            asm_neg    = {t2_out.neg[2], 1'b0, t2_out.neg[1], t2_out.neg[0]};
         end
         default: begin
            asm_mag[0] = quo1[0]; asm_mag[1] = quo1[1];
            asm_mag[2] = quo1[2]; asm_mag[3] = own_ext;
            asm_neg    = {1'b0, t2_out.neg[2], t2_out.neg[1], t2_out.neg[0]};
         end
      endcase
   end

   logic           s3_vld_ff, s3_degen_ff;
   logic [MW-1:0]  s3_mag_ff [4];
   logic [3:0]     s3_neg_ff;
   logic [MW-1:0]  s3_or_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= dv1_vld;
      end
      s3_degen_ff <= t2_out.degen;
      s3_mag_ff   <= asm_mag;
      s3_neg_ff   <= asm_neg;
      // The largest magnitude has the same top bit as the OR of all four.
      s3_or_ff    <= asm_mag[0] | asm_mag[1] | asm_mag[2] | asm_mag[3];
   end

   logic [K_W-1:0]  blen, k_in;

   always_comb begin
      blen = '0;
      for (int b = 0; b < MW; b++) begin
         if (s3_or_ff[b]) begin
            blen = K_W'(b + 1);
         end
      end
      if (int'(blen) > NB) begin
         k_in = K_W'(int'(blen) - NB);
      end else begin
         k_in = '0;
      end
   end

   logic            s4_vld_ff, s4_degen_ff;
   logic [MW-1:0]   s4_mag_ff [4];
   logic [3:0]      s4_neg_ff;
   logic [K_W-1:0]  s4_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_degen_ff <= s3_degen_ff;
      s4_mag_ff   <= s3_mag_ff;
      s4_neg_ff   <= s3_neg_ff;
      s4_k_ff     <= k_in;
   end

   logic [SH_W-1:0]  shifted [4];
   logic [NB-1:0]    m_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         shifted[i] = SH_W'(s4_mag_ff[i]) >> s4_k_ff;
         m_in[i]    = shifted[i][NB-1:0];
      end
   end

   logic             s5_vld_ff, s5_degen_ff;
   logic [NB-1:0]    s5_m_ff [4];
   logic [3:0]       s5_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      s5_degen_ff <= s4_degen_ff;
      s5_m_ff     <= m_in;
      s5_neg_ff   <= s4_neg_ff;
   end

   logic               s6_vld_ff, s6_degen_ff;
   logic [2*NB-1:0]    s6_sq_ff [4];
   logic [NB-1:0]      s6_m_ff [4];
   logic [3:0]         s6_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      for (int i = 0; i < 4; i++) begin
         s6_sq_ff[i] <= (2*NB)'(s5_m_ff[i]) * (2*NB)'(s5_m_ff[i]);
      end
      s6_degen_ff <= s5_degen_ff;
      s6_m_ff     <= s5_m_ff;
      s6_neg_ff   <= s5_neg_ff;
   end

   logic              s7_vld_ff;
   logic [SQ2_W-1:0]  s7_sum_ff;
   tag3_type          s7_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else begin
         s7_vld_ff <= s6_vld_ff;
      end
      s7_sum_ff <= SQ2_W'(s6_sq_ff[0]) + SQ2_W'(s6_sq_ff[1])
                 + SQ2_W'(s6_sq_ff[2]) + SQ2_W'(s6_sq_ff[3]);
      s7_tag_ff.degen <= s6_degen_ff;
      s7_tag_ff.neg   <= s6_neg_ff;
      for (int i = 0; i < 4; i++) begin
         s7_tag_ff.m[i] <= s6_m_ff[i];
      end
   end

   tag3_type       t3_out;
   logic           sq2_vld;
   logic [R2-1:0]  norm;

   rmq_sqrt_pipe #(
      .IN_W  (SQ2_W),
      .TAG_W ($bits(tag3_type))
   ) u_sqrt_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s7_vld_ff),
      .in_rad    (s7_sum_ff),
      .in_tag    (s7_tag_ff),
      .out_valid (sq2_vld),
      .out_root  (norm),
      .out_tag   (t3_out)
   );

   logic [3:0][QW-1:0]  div2_num;
   tag4_type            t4_in, t4_out;
   logic                dv2_vld;
   logic [3:0][QW-1:0]  quo2;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         div2_num[i] = {t3_out.m[i], {FRAC_BITS{1'b0}}};
      end
      t4_in.degen = t3_out.degen || (norm == '0);
      t4_in.neg   = t3_out.neg;
   end

   rmq_div_pipe #(
      .NUM_W (QW),
      .DEN_W (R2),
      .LANES (4),
      .TAG_W ($bits(tag4_type))
   ) u_div_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq2_vld),
      .in_num    (div2_num),
      .in_den    (norm),
      .in_tag    (t4_in),
      .out_valid (dv2_vld),
      .out_quo   (quo2),
      .out_tag   (t4_out)
   );

   // ----------------------------------------------------- sign and saturate
   logic [DATA_WIDTH-1:0]  res_in [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (t4_out.neg[i]) begin
            res_in[i] = (quo2[i] > NEG_MAX) ? NEG_MAX[DATA_WIDTH-1:0]
                                            : DATA_WIDTH'(-quo2[i]);
         end else begin
            res_in[i] = (quo2[i] > POS_MAX) ? POS_MAX[DATA_WIDTH-1:0]
                                            : quo2[i][DATA_WIDTH-1:0];
         end
      end
      if (t4_out.degen) begin
         res_in[0] = W_ONE;
         res_in[1] = '0;
         res_in[2] = '0;
         res_in[3] = '0;
      end
   end

   logic                   out_vld_ff, out_degen_ff;
   logic [DATA_WIDTH-1:0]  out_q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv2_vld;
      end
      out_degen_ff <= t4_out.degen;
      out_q_ff     <= res_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_quat_w     = out_q_ff[0];
   assign rsp_quat_x     = out_q_ff[1];
   assign rsp_quat_y     = out_q_ff[2];
   assign rsp_quat_z     = out_q_ff[3];
   assign rsp_degenerate = out_degen_ff;

endmodule

// ===== rtl/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
module rmq_checker #(
   parameter int DATA_WIDTH = 18
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic signed [DATA_WIDTH-1:0]  rsp_quat_w,
   input logic signed [DATA_WIDTH-1:0]  rsp_quat_x,
   input logic signed [DATA_WIDTH-1:0]  rsp_quat_y,
   input logic signed [DATA_WIDTH-1:0]  rsp_quat_z,
   input logic                          rsp_degenerate
);

   // The pipeline never holds a request off.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("busy raised while a request was offered");

   // A degenerate result carries no vector part and a positive scalar.
   a_degen_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0 &&
         rsp_quat_w > 0)
      else $error("degenerate result is not the identity");

   // Reset flushes every request in flight.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_quat_w     (rsp_quat_w),
   .rsp_quat_x     (rsp_quat_x),
   .rsp_quat_y     (rsp_quat_y),
   .rsp_quat_z     (rsp_quat_z),
   .rsp_degenerate (rsp_degenerate)
);
